// ===== design/page_bitmap_allocator_core_assert.svh =====
// assertion macros for the checker file of the page bitmap allocator
// no dependencies; the user module must provide clk and rst_n
`ifndef PAGE_BITMAP_ALLOCATOR_CORE_ASSERT_SVH
`define PAGE_BITMAP_ALLOCATOR_CORE_ASSERT_SVH

// same-cycle implication
`define PBA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pba assertion failed");

// next-cycle implication
`define PBA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pba assertion failed");

`endif

// ===== design/pba_pkg.sv =====
// shared types, constants and helpers for the page bitmap allocator
// no dependencies
`timescale 1ns / 1ps

package pba_pkg;

  localparam int NUM_PAGES_DEF = 65536;
  localparam int CNT_W         = 17;
  localparam int PAGE_W        = 17;
  localparam int START_W       = 16;
  localparam int WORD_BITS     = 32;
  localparam int BIT_W         = 5;

  localparam logic [CNT_W-1:0] TOTAL_RST = 17'h10000;
  localparam logic [CNT_W-1:0] CNT_MAX   = 17'h1FFFF;

  typedef enum logic [1:0] {
    OP_LOCK      = 2'd0,
    OP_FREE      = 2'd1,
    OP_RESERVE   = 2'd2,
    OP_UNRESERVE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MOD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clr_wr;
    logic load;
    logic rd;
    logic modify;
    logic finish;
  } pba_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic more;
    logic out_busy;
  } pba_sts_t;

  function automatic logic [CNT_W-1:0] inc_sat(input logic [CNT_W-1:0] v);
    inc_sat = (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [CNT_W-1:0] dec_sat(input logic [CNT_W-1:0] v);
    dec_sat = (v == '0) ? v : v - 1'b1;
  endfunction

endpackage

// ===== design/pba_ctrl.sv =====
// sequencer for the page bitmap allocator: clear pass, page walk, result hand-off
// depends on pba_pkg
`timescale 1ns / 1ps

module pba_ctrl import pba_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_we,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  pba_sts_t sts,
  output pba_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (sts.clr_last) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_tvalid) state_nxt = ST_READ;
      ST_READ:  state_nxt = sts.more ? ST_MOD : ST_DONE;
      ST_MOD:   state_nxt = ST_READ;
      ST_DONE:  if (!sts.out_busy) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
    // a map-size write restarts the clear pass
    if (cfg_we) state_nxt = ST_CLEAR;
  end

  always_comb begin
    cmd        = '0;
    in_tready  = 1'b0;
    case (state_r)
      ST_CLEAR: cmd.clr_wr = 1'b1;
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_READ:  cmd.rd = sts.more;
      ST_MOD:   cmd.modify = 1'b1;
      ST_DONE:  cmd.finish = !sts.out_busy;
      default:  cmd = '0;
    endcase
  end

endmodule

// ===== design/pba_dp.sv =====
// datapath of the page bitmap allocator: bitmap memory, counters, walk pointer, result
// depends on pba_pkg
`timescale 1ns / 1ps

module pba_dp import pba_pkg::*; #(
  parameter int NUM_PAGES = NUM_PAGES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CNT_W-1:0]   cfg_wdata,
  input  op_t                op_in,
  input  logic [START_W-1:0] start_in,
  input  logic [CNT_W-1:0]   count_in,
  input  logic               out_tready,
  input  pba_cmd_t           cmd,
  output pba_sts_t           sts,
  output logic               out_tvalid,
  output logic [CNT_W-1:0]   free_out,
  output logic [CNT_W-1:0]   used_out,
  output logic [CNT_W-1:0]   reserved_out,
  output logic [CNT_W-1:0]   changed_out,
  output logic               oor_out
);

  localparam int ROWS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int RAW  = $clog2(ROWS);

  logic [WORD_BITS-1:0] mem [ROWS];

  logic [CNT_W-1:0]     total_r, total_nxt, lim;
  logic [CNT_W-1:0]     free_r, used_r, res_r;
  logic [PAGE_W-1:0]    page_r;
  logic [PAGE_W:0]      end_r, sum, lim_x;
  op_t                  op_r;
  logic                 oor_r;
  logic [CNT_W-1:0]     chg_r;
  logic [RAW-1:0]       clr_cnt_r, row;
  logic [BIT_W-1:0]     bi;
  logic [WORD_BITS-1:0] rdata_r, wdata;
  logic                 setting, resv, change;
  logic                 out_valid_r;

  function automatic logic [CNT_W-1:0] eff(input logic [CNT_W-1:0] t);
    eff = (32'(t) < NUM_PAGES) ? t : CNT_W'(NUM_PAGES);
  endfunction

  always_comb begin
    total_nxt = total_r;
    if (!rst_n) total_nxt = TOTAL_RST;
    else if (cfg_we) total_nxt = cfg_wdata;
  end

  always_ff @(posedge clk) begin
    total_r <= total_nxt;
  end

  assign lim     = eff(total_r);
  assign lim_x   = {1'b0, lim};
  assign sum     = {2'b00, start_in} + {1'b0, count_in};
  assign setting = (op_r == OP_LOCK) || (op_r == OP_RESERVE);
  assign resv    = (op_r == OP_RESERVE) || (op_r == OP_UNRESERVE);
  assign row     = RAW'(page_r >> BIT_W);
  assign bi      = page_r[BIT_W-1:0];
  assign change  = (rdata_r[bi] != setting);

  always_comb begin
    wdata     = rdata_r;
    wdata[bi] = setting;
  end

  // counters
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      free_r <= eff(total_nxt);
      used_r <= '0;
      res_r  <= '0;
    end else if (cmd.modify && change) begin
      if (setting) begin
        free_r <= dec_sat(free_r);
        if (resv) res_r <= inc_sat(res_r);
        else used_r <= inc_sat(used_r);
      end else begin
        free_r <= inc_sat(free_r);
        if (resv) res_r <= dec_sat(res_r);
        else used_r <= dec_sat(used_r);
      end
    end
  end

  // walk state of the current item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= op_in;
      page_r <= {1'b0, start_in};
      end_r  <= (sum < lim_x) ? sum : lim_x;
      oor_r  <= (count_in != '0) && (sum > lim_x);
      chg_r  <= '0;
    end else if (cmd.modify) begin
      page_r <= page_r + 1'b1;
      if (change) chg_r <= chg_r + 1'b1;
    end
  end

  // clear sweep pointer
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // bitmap memory, one row of pages per word
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      mem[clr_cnt_r] <= '0;
    end else if (cmd.modify && change) begin
      mem[row] <= wdata;
    end
    if (cmd.rd) begin
      rdata_r <= mem[row];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      free_out     <= free_r;
      used_out     <= used_r;
      reserved_out <= res_r;
      changed_out  <= chg_r;
      oor_out      <= oor_r;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign sts.clr_last = (clr_cnt_r == RAW'(ROWS - 1));
  assign sts.more     = ({1'b0, page_r} < end_r);
  assign sts.out_busy = out_valid_r && !out_tready;

endmodule

// ===== design/page_bitmap_allocator_core.sv =====
// page bitmap allocator: each accepted item walks its pages in range in order, per page
// walked one bitmap row read and, when the bit changes, one row write; then the result is registered
// one item at a time: the next item is accepted only after the result of the last is registered;
// a stalled result holds the walk in its final state and blocks the input
// reset (rst_n low, synchronous) and every total_pages write run a clear pass over all
// ceil(NUM_PAGES / 32) bitmap rows (2048 by default) with in_tready low
`timescale 1ns / 1ps

// top level: stream ports, field packing, controller and datapath
// depends on pba_pkg, pba_ctrl, pba_dp
module page_bitmap_allocator_core import pba_pkg::*; #(
  parameter int NUM_PAGES = NUM_PAGES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: total_pages
  input  logic        cfg_we,
  input  logic [16:0] cfg_wdata,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // start_page[15:0], page_count[32:16], zero pad
  input  logic [1:0]  in_tuser,   // operation[1:0]
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // free[16:0], used[33:17], reserved[50:34],
                                  // pages_changed[67:51], zero pad
  output logic        out_tuser   // out_of_range
);

  pba_cmd_t         cmd;
  pba_sts_t         sts;
  logic [CNT_W-1:0] free_pages, used_pages, reserved_pages, pages_changed;

  // sequencer: clear pass after reset / config, then read-modify-write per page
  pba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // bitmap rows, counters and the result register
  pba_dp #(
    .NUM_PAGES (NUM_PAGES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .op_in        (op_t'(in_tuser)),
    .start_in     (in_tdata[15:0]),
    .count_in     (in_tdata[32:16]),
    .out_tready   (out_tready),
    .cmd          (cmd),
    .sts          (sts),
    .out_tvalid   (out_tvalid),
    .free_out     (free_pages),
    .used_out     (used_pages),
    .reserved_out (reserved_pages),
    .changed_out  (pages_changed),
    .oor_out      (out_tuser)
  );

  // result packing, lowest field first
  assign out_tdata = {4'b0000, pages_changed, reserved_pages, used_pages, free_pages};

endmodule

// ===== design/pba_chk.sv =====
// port-level checker for the page bitmap allocator, bound to the top level
// depends on page_bitmap_allocator_core_assert.svh
`timescale 1ns / 1ps
`include "page_bitmap_allocator_core_assert.svh"

module pba_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_we,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata
);

  // a stalled result keeps its item
  `PBA_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // an accepted item keeps the block busy at least for the next cycle
  `PBA_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)

  // a map-size write starts the clear pass
  `PBA_ASSERT_NEXT(a_clear_after_cfg, cfg_we, !in_tready)

endmodule

bind page_bitmap_allocator_core pba_chk u_pba_chk (.*);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// self-checking testbench for page_bitmap_allocator_core: directed and random page requests,
// a shadow bitmap with free/used/reserved counters, in-order checking of every result item
// depends on pba_pkg and page_bitmap_allocator_core

module testbench;
  import pba_pkg::*;

  // one queued action for the driver: a total_pages write or a page request
  typedef struct {
    bit          is_cfg;
    logic [16:0] total;
    op_t         op;
    logic [15:0] start;
    logic [16:0] count;
  } request_t;

  // counters and flags expected back for one request
  typedef struct {
    logic [16:0] free_pg;
    logic [16:0] used_pg;
    logic [16:0] rsvd_pg;
    logic [16:0] changed;
    logic        oor;
  } tally_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [16:0] cfg_wdata  = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;   // start_page[15:0], page_count[32:16], zero pad
  logic [1:0]  in_tuser   = '0;   // operation[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;         // free[16:0], used[33:17], reserved[50:34], changed[67:51]
  logic        out_tuser;         // out_of_range

  page_bitmap_allocator_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // shadow copy of the allocator state
  bit          shadow_map [0:NUM_PAGES_DEF-1];
  logic [16:0] total_reg;
  logic [16:0] free_cnt;
  logic [16:0] used_cnt;
  logic [16:0] rsvd_cnt;

  request_t    request_q [$];   // filled up front, drained by the driver
  tally_t      tally_q [$];     // one entry per accepted request, oldest first
  request_t    cur_req;         // request currently offered on the input
  int          err_cnt = 0;
  int          n_items = 0;     // page requests queued, each returns one result

  // pages actually managed: the register, capped at the map size
  function automatic int unsigned managed_pages();
    return (total_reg < NUM_PAGES_DEF) ? total_reg : NUM_PAGES_DEF;
  endfunction

  function automatic logic [16:0] cnt_up(logic [16:0] v);
    return (v == CNT_MAX) ? v : v + 17'd1;
  endfunction

  function automatic logic [16:0] cnt_dn(logic [16:0] v);
    return (v == 17'd0) ? v : v - 17'd1;
  endfunction

  // a total_pages write wipes the map and restarts the counters
  function automatic void wipe_map();
    foreach (shadow_map[i]) shadow_map[i] = 1'b0;
    free_cnt = 17'(managed_pages());
    used_cnt = '0;
    rsvd_cnt = '0;
  endfunction

  // walk the page range in order and return the counters after the request
  function automatic tally_t walk_range(op_t op, logic [15:0] start, logic [16:0] count);
    tally_t      r;
    int unsigned lim;
    int unsigned pg;
    bit          setting;
    bit          rsv_kind;
    lim      = managed_pages();
    setting  = (op == OP_LOCK) || (op == OP_RESERVE);
    rsv_kind = (op == OP_RESERVE) || (op == OP_UNRESERVE);
    r.changed = '0;
    r.oor     = 1'b0;
    for (int unsigned t = 0; t < count; t++) begin
      pg = start + t;
      if (pg >= lim) begin
        r.oor = 1'b1;
      end else if (shadow_map[pg] != setting) begin
        shadow_map[pg] = setting;
        // the map does not know why a page is taken, so a mismatched release
        // simply bottoms out on the other counter
        if (setting) begin
          free_cnt = cnt_dn(free_cnt);
          if (rsv_kind) rsvd_cnt = cnt_up(rsvd_cnt);
          else used_cnt = cnt_up(used_cnt);
        end else begin
          free_cnt = cnt_up(free_cnt);
          if (rsv_kind) rsvd_cnt = cnt_dn(rsvd_cnt);
          else used_cnt = cnt_dn(used_cnt);
        end
        r.changed++;
      end
    end
    r.free_pg = free_cnt;
    r.used_pg = used_cnt;
    r.rsvd_pg = rsvd_cnt;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [16:0] got, logic [16:0] want);
    $display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
    err_cnt++;
  endtask

  function automatic void add_req(op_t op, int unsigned start, int unsigned count);
    request_t r;
    r.is_cfg = 1'b0;
    r.total  = '0;
    r.op     = op;
    r.start  = start[15:0];
    r.count  = count[16:0];
    request_q.push_back(r);
  endfunction

  function automatic void add_cfg(int unsigned total);
    request_t r;
    r.is_cfg = 1'b1;
    r.total  = total[16:0];
    r.op     = OP_LOCK;
    r.start  = '0;
    r.count  = '0;
    request_q.push_back(r);
  endfunction

  // random phase: mostly short requests clustered in a window so that they overlap,
  // plus scattered requests that may run far past the end of the managed range
  function automatic void add_phase(int unsigned total, int n);
    int unsigned lim;
    int unsigned win;
    int unsigned base;
    int unsigned st;
    int unsigned cnt;
    lim  = (total < NUM_PAGES_DEF) ? total : NUM_PAGES_DEF;
    win  = (lim < 48) ? lim + 2 : 48;
    base = 0;
    add_cfg(total);
    for (int i = 0; i < n; i++) begin
      if (i % 10 == 0) base = (lim > win) ? $urandom_range(0, lim - win / 2) : 0;
      if ($urandom_range(0, 99) < 85) begin
        st  = base + $urandom_range(0, win);
        cnt = $urandom_range(0, 24);
      end else begin
        st  = $urandom_range(0, 65535);
        // long walks only where few pages are managed
        cnt = (lim <= 4096) ? $urandom_range(0, 65536) : $urandom_range(0, 64);
      end
      if (st > 65535) st = 65535;
      add_req(op_t'($urandom_range(0, 3)), st, cnt);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // driver: offers queued requests, predicts each one on acceptance, and writes
  // total_pages only once all results are back and the block has settled
  // ---------------------------------------------------------------------------
  int gap_left  = 0;
  int quiet_cnt = 0;

  always @(posedge clk) begin
    request_t nxt;
    logic     nx_valid;
    logic     nx_we;
    nx_valid = in_tvalid;
    nx_we    = 1'b0;
    if (!rst_n) begin
      nx_valid = 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        tally_q.push_back(walk_range(cur_req.op, cur_req.start, cur_req.count));
        nx_valid = 1'b0;
      end
      if (!nx_valid) begin
        quiet_cnt = (tally_q.size() == 0) ? quiet_cnt + 1 : 0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (request_q.size() > 0) begin
          if (request_q[0].is_cfg) begin
            // block idle: no result pending and the quiet counter has reached its threshold
            if (quiet_cnt >= 8) begin
              nxt       = request_q.pop_front();
              nx_we     = 1'b1;
              cfg_wdata <= nxt.total;
              total_reg = nxt.total;
              wipe_map();
              quiet_cnt = 0;
            end
          end else begin
            cur_req  = request_q.pop_front();
            nx_valid = 1'b1;
            in_tdata <= {7'd0, cur_req.count, cur_req.start};
            in_tuser <= cur_req.op;
            // idle burst after this item, none near the end of the run
            if (request_q.size() > 40 && $urandom_range(0, 3) == 0)
              gap_left = $urandom_range(1, 12);
          end
        end
      end
    end
    in_tvalid <= nx_valid;
    cfg_we    <= nx_we;
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each result item against the oldest expectation and drives
  // out_tready with random stall bursts and one long hold-off
  // ---------------------------------------------------------------------------
  int stall_left   = 0;
  int hold_left    = 0;
  int results_seen = 0;
  bit hold_done    = 1'b0;

  always @(posedge clk) begin
    tally_t want;
    logic   nx_ready;
    nx_ready = 1'b0;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (tally_q.size() == 0) begin
          report_mismatch("unexpected result, free_pages", out_tdata[16:0], '0);
        end else begin
          want = tally_q.pop_front();
          if (out_tdata[16:0] !== want.free_pg)
            report_mismatch("free_pages", out_tdata[16:0], want.free_pg);
          if (out_tdata[33:17] !== want.used_pg)
            report_mismatch("used_pages", out_tdata[33:17], want.used_pg);
          if (out_tdata[50:34] !== want.rsvd_pg)
            report_mismatch("reserved_pages", out_tdata[50:34], want.rsvd_pg);
          if (out_tdata[67:51] !== want.changed)
            report_mismatch("pages_changed", out_tdata[67:51], want.changed);
          if (out_tuser !== want.oor)
            report_mismatch("out_of_range", {16'd0, out_tuser}, {16'd0, want.oor});
        end
      end
      // long hold-off so the block backs up and stalls its input
      if (hold_left > 0) begin
        hold_left--;
      end else if (!hold_done && results_seen >= 60) begin
        hold_done = 1'b1;
        hold_left = 300;
      end else if (stall_left > 0) begin
        stall_left--;
      end else if (request_q.size() > 40 && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
      end else begin
        nx_ready = 1'b1;
      end
    end
    out_tready <= nx_ready;
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    total_reg = TOTAL_RST;
    wipe_map();

    // reset total: zero count, overlaps, mixed releases, range end
    add_req(OP_LOCK, 0, 0);
    add_req(OP_LOCK, 0, 8);
    add_req(OP_LOCK, 4, 8);
    add_req(OP_RESERVE, 10, 6);
    add_req(OP_FREE, 2, 4);             // frees locked pages
    add_req(OP_UNRESERVE, 0, 16);       // reserved count bottoms out at zero
    add_req(OP_UNRESERVE, 100, 3);
    add_req(OP_FREE, 65535, 1);
    add_req(OP_LOCK, 65534, 4);
    add_req(OP_LOCK, 65535, 65536);

    // full-map walks: free count reaches zero, every page changes
    add_cfg(65536);
    add_req(OP_LOCK, 0, 65536);
    add_req(OP_RESERVE, 5, 3);
    add_req(OP_UNRESERVE, 0, 65536);
    add_req(OP_LOCK, 0, 65536);
    add_req(OP_FREE, 0, 10);
    add_req(OP_LOCK, 3, 4);

    // zero total: everything out of range
    add_cfg(0);
    add_req(OP_LOCK, 0, 5);
    add_req(OP_FREE, 7, 0);

    add_cfg(65535);
    add_req(OP_RESERVE, 65535, 1);
    add_req(OP_UNRESERVE, 65534, 2);

    add_cfg(1);
    add_req(OP_LOCK, 0, 2);
    add_req(OP_RESERVE, 0, 1);

    // random phases across several totals
    add_phase(64, 63);
    add_phase($urandom_range(2, 1000), 63);
    add_phase(4096, 63);
    add_phase(65535, 63);
    add_phase(65536, 63);
    add_phase($urandom_range(1, 63), 63);

    foreach (request_q[i]) if (!request_q[i].is_cfg) n_items++;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // every page request returns exactly one result
    while (results_seen < n_items)
      @(posedge clk);
    repeat (40) @(posedge clk);

    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog, well beyond the three full-map walks and the clear passes
  initial begin
    #48_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
